// File: hw/rtl/scw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Soft clip waveshaper package
// Widths, register codes and reset values shared by the waveshaper RTL.
// ----------------------------------------------------------------------------
package scw_pkg;

  localparam int SAMPLE_WIDTH = 24;
  localparam int FRAC         = SAMPLE_WIDTH - 1;

  localparam int GAIN_W = 16;
  localparam int THR_W  = 23;
  localparam int CFG_W  = 32;
  localparam int CFG_IDX_W = 3;

  // Number of register stages, the output register included.
  localparam int NST = 8;

  // Magnitude after the pre-gain, rescaled to 32 fractional bits.
  localparam int X_W   = SAMPLE_WIDTH + GAIN_W;
  localparam int M_SHR = (FRAC + 12 >= 32) ? (FRAC + 12 - 32) : 0;
  localparam int M_SHL = (FRAC + 12 < 32) ? (32 - FRAC - 12) : 0;
  localparam int M_RND = (M_SHR > 0) ? (1 << (M_SHR - 1)) : 0;
  localparam int M_W   = X_W + 1 - M_SHR + M_SHL;

  localparam int T_W     = THR_W + 9;
  localparam int LIN_W   = M_W + GAIN_W;
  localparam int CLIPP_W = T_W + GAIN_W;
  localparam int CMP_W   = M_W + 12;

  // Knee path: the magnitude stays below 2^36 there.
  localparam int MR_W  = 25;
  localparam int SQF_W = 2 * MR_W;
  localparam int SQ_W  = 29;

  localparam int V_W  = 46;
  localparam int VL_W = V_W - 1;
  localparam int Z_W  = V_W + GAIN_W + 1;
  localparam int R_SH = 44 - FRAC;
  localparam int R_W  = Z_W + 1 - R_SH;

  localparam logic [SAMPLE_WIDTH-1:0] SAT_POS = {1'b0, {FRAC{1'b1}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INPUT_GAIN  = 3'd0,
    CFG_OUTPUT_GAIN = 3'd1,
    CFG_KNEE_THRESH = 3'd2,
    CFG_LIN_SLOPE   = 3'd3,
    CFG_CLIP_LEVEL  = 3'd4,
    CFG_QUAD_A      = 3'd5,
    CFG_QUAD_B      = 3'd6,
    CFG_QUAD_C      = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    REG_LINEAR = 2'd0,
    REG_KNEE   = 2'd1,
    REG_CLIP   = 2'd2
  } region_e;

  localparam logic [GAIN_W-1:0]        IG_RST = 16'd4096;
  localparam logic [GAIN_W-1:0]        OG_RST = 16'd2048;
  localparam logic [THR_W-1:0]         KT_RST = 23'd1258291;
  localparam logic [GAIN_W-1:0]        LS_RST = 16'd16384;
  localparam logic [GAIN_W-1:0]        CL_RST = 16'd6963;
  localparam logic signed [GAIN_W-1:0] QA_RST = -16'sd14542;
  localparam logic signed [GAIN_W-1:0] QB_RST = 16'sd20747;
  localparam logic signed [GAIN_W-1:0] QC_RST = -16'sd327;

endpackage

// File: hw/rtl/soft_clip_waveshaper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Soft clip waveshaper
// Symmetrical soft clipping overdrive: pre-gain, linear, quadratic knee or
// hard clip by magnitude, post-gain, rounding and saturation.
// ----------------------------------------------------------------------------
// Samples enter on the in channel (in_valid_i, in_ready_o, sample_in_i) and
// leave on the out channel (out_valid_o, out_ready_i, sample_out_o, region_o,
// saturated_o), one result beat for every input beat, in order.
// The datapath is an eight stage pipeline, and one beat per cycle is sustained
// while the receiver does not stall.
// Each stage holds one level of multiplications or of wide adds and compares.
// Registers are written through the cfg channel (cfg_valid_i, cfg_index_i,
// cfg_data_i), which is always ready; write them only while the pipeline is
// empty. Reset empties the pipeline and loads the default register values.
// When the receiver stalls, the output holds its beat and the stages behind
// it keep filling empty slots; input is refused only when every stage is full.
// ----------------------------------------------------------------------------
module soft_clip_waveshaper (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  logic [scw_pkg::CFG_IDX_W-1:0]             cfg_index_i,
  input  logic [scw_pkg::CFG_W-1:0]                 cfg_data_i,
  input  logic                                      in_valid_i,
  output logic                                      in_ready_o,
  input  logic signed [scw_pkg::SAMPLE_WIDTH-1:0]   sample_in_i,
  output logic                                      out_valid_o,
  input  logic                                      out_ready_i,
  output logic signed [scw_pkg::SAMPLE_WIDTH-1:0]   sample_out_o,
  output logic [1:0]                                region_o,
  output logic                                      saturated_o
);
  import scw_pkg::*;

  logic [GAIN_W-1:0]        in_gain_q, in_gain_d;
  logic [GAIN_W-1:0]        out_gain_q, out_gain_d;
  logic [THR_W-1:0]         knee_q, knee_d;
  logic [GAIN_W-1:0]        slope_q, slope_d;
  logic [GAIN_W-1:0]        clip_q, clip_d;
  logic signed [GAIN_W-1:0] qa_q, qa_d;
  logic signed [GAIN_W-1:0] qb_q, qb_d;
  logic signed [GAIN_W-1:0] qc_q, qc_d;

  logic [NST-1:0] vld_q, vld_d;
  logic [NST-1:0] en;

  logic                      s1_neg_q, s1_neg_d;
  logic [X_W-1:0]            s1_x_q, s1_x_d;
  logic                      s2_neg_q;
  logic [M_W-1:0]            s2_m_q, s2_m_d;
  logic                      s3_neg_q;
  logic [M_W-1:0]            s3_m_q;
  logic [LIN_W-1:0]          s3_lin_q, s3_lin_d;
  logic [CLIPP_W-1:0]        s3_clipp_q, s3_clipp_d;
  logic                      s3_le_q, s3_le_d;
  logic [MR_W-1:0]           s3_mr_q, s3_mr_d;
  logic                      s4_neg_q;
  region_e                   s4_region_q, s4_region_d;
  logic [VL_W-1:0]           s4_vlin_q, s4_vlin_d;
  logic [SQF_W-1:0]          s4_sq_q, s4_sq_d;
  logic [MR_W-1:0]           s4_mr_q;
  logic                      s5_neg_q;
  region_e                   s5_region_q;
  logic [VL_W-1:0]           s5_vlin_q;
  logic signed [V_W-1:0]     s5_pa_q, s5_pa_d;
  logic signed [V_W-1:0]     s5_pb_q, s5_pb_d;
  region_e                   s6_region_q;
  logic signed [V_W-1:0]     s6_v_q, s6_v_d;
  region_e                   s7_region_q;
  logic signed [Z_W-1:0]     s7_z_q, s7_z_d;
  region_e                   s8_region_q;
  logic [SAMPLE_WIDTH-1:0]   s8_out_q, s8_out_d;
  logic                      s8_sat_q, s8_sat_d;

  logic [SAMPLE_WIDTH-1:0]   mag;
  logic [X_W:0]              xr;
  logic [T_W-1:0]            thr;
  logic [M_W-1:0]            mrr;
  logic [LIN_W:0]            linr;
  logic [SQF_W:0]            sqr;
  logic [SQ_W-1:0]           sq;
  logic signed [V_W-1:0]     cterm;
  logic signed [V_W-1:0]     vsel;
  logic                      zneg;
  logic [Z_W-1:0]            zmag;
  logic [Z_W:0]              rr;
  logic [R_W-1:0]            rnd;
  logic [R_W-1:0]            lim;
  logic [R_W-1:0]            rc;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    in_gain_d  = in_gain_q;
    out_gain_d = out_gain_q;
    knee_d     = knee_q;
    slope_d    = slope_q;
    clip_d     = clip_q;
    qa_d       = qa_q;
    qb_d       = qb_q;
    qc_d       = qc_q;
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_INPUT_GAIN:  in_gain_d  = cfg_data_i[GAIN_W-1:0];
        CFG_OUTPUT_GAIN: out_gain_d = cfg_data_i[GAIN_W-1:0];
        CFG_KNEE_THRESH: knee_d     = cfg_data_i[THR_W-1:0];
        CFG_LIN_SLOPE:   slope_d    = cfg_data_i[GAIN_W-1:0];
        CFG_CLIP_LEVEL:  clip_d     = cfg_data_i[GAIN_W-1:0];
        CFG_QUAD_A:      qa_d       = $signed(cfg_data_i[GAIN_W-1:0]);
        CFG_QUAD_B:      qb_d       = $signed(cfg_data_i[GAIN_W-1:0]);
        CFG_QUAD_C:      qc_d       = $signed(cfg_data_i[GAIN_W-1:0]);
      endcase
    end
  end

  // Pipeline flow control: a stage loads when it is empty or moves on.
  always_comb begin
    en[NST-1] = !vld_q[NST-1] || out_ready_i;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
    vld_d[0] = en[0] ? in_valid_i : vld_q[0];
    for (int k = 1; k < NST; k++) begin
      vld_d[k] = en[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  assign in_ready_o = en[0];

  // Datapath.
  assign thr = {knee_q, 9'b0};

  always_comb begin
    s1_neg_d = sample_in_i[SAMPLE_WIDTH-1];
    mag = s1_neg_d ? (SAMPLE_WIDTH'(0) - $unsigned(sample_in_i)) : $unsigned(sample_in_i);
    s1_x_d = X_W'(mag) * X_W'(in_gain_q);

    xr = {1'b0, s1_x_q} + (X_W + 1)'(M_RND);
    s2_m_d = M_W'(xr >> M_SHR) << M_SHL;

    s3_lin_d   = LIN_W'(s2_m_q) * LIN_W'(slope_q);
    s3_clipp_d = CLIPP_W'(thr) * CLIPP_W'(slope_q);
    s3_le_d    = s2_m_q <= M_W'(thr);
    mrr        = s2_m_q + M_W'(2048);
    s3_mr_d    = MR_W'(mrr >> 12);

    if (s3_le_q) begin
      s4_region_d = REG_LINEAR;
    end else if ((CMP_W'(s3_m_q) << 12) >= CMP_W'(s3_clipp_q)) begin
      s4_region_d = REG_CLIP;
    end else begin
      s4_region_d = REG_KNEE;
    end
    linr      = (LIN_W + 1)'(s3_lin_q) + (LIN_W + 1)'(2048);
    s4_vlin_d = VL_W'(linr >> 12);
    s4_sq_d   = SQF_W'(s3_mr_q) * SQF_W'(s3_mr_q);

    sqr     = (SQF_W + 1)'(s4_sq_q) + (SQF_W + 1)'(1 << 19);
    sq      = SQ_W'(sqr >> 20);
    s5_pa_d = V_W'(qa_q) * V_W'($signed({1'b0, sq}));
    s5_pb_d = V_W'(qb_q) * V_W'($signed({1'b0, s4_mr_q}));

    cterm = {{(V_W - GAIN_W - 20){qc_q[GAIN_W-1]}}, qc_q, 20'b0};
    case (s5_region_q)
      REG_LINEAR: vsel = $signed({1'b0, s5_vlin_q});
      REG_CLIP:   vsel = $signed(V_W'({clip_q, 20'b0}));
      default:    vsel = s5_pa_q + s5_pb_q + cterm;
    endcase
    s6_v_d = s5_neg_q ? -vsel : vsel;

    s7_z_d = Z_W'(s6_v_q) * Z_W'($signed({1'b0, out_gain_q}));

    zneg = s7_z_q[Z_W-1];
    zmag = zneg ? (Z_W'(0) - $unsigned(s7_z_q)) : $unsigned(s7_z_q);
    rr   = (Z_W + 1)'(zmag) + (Z_W + 1)'(1 << (R_SH - 1));
    rnd  = R_W'(rr >> R_SH);
    lim  = R_W'(SAT_POS) + R_W'(zneg);
    s8_sat_d = rnd > lim;
    rc   = s8_sat_d ? lim : rnd;
    s8_out_d = zneg ? (SAMPLE_WIDTH'(0) - SAMPLE_WIDTH'(rc)) : SAMPLE_WIDTH'(rc);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q      <= '0;
      in_gain_q  <= IG_RST;
      out_gain_q <= OG_RST;
      knee_q     <= KT_RST;
      slope_q    <= LS_RST;
      clip_q     <= CL_RST;
      qa_q       <= QA_RST;
      qb_q       <= QB_RST;
      qc_q       <= QC_RST;
    end else begin
      vld_q      <= vld_d;
      in_gain_q  <= in_gain_d;
      out_gain_q <= out_gain_d;
      knee_q     <= knee_d;
      slope_q    <= slope_d;
      clip_q     <= clip_d;
      qa_q       <= qa_d;
      qb_q       <= qb_d;
      qc_q       <= qc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s1_neg_q <= s1_neg_d;
      s1_x_q   <= s1_x_d;
    end
    if (en[1]) begin
      s2_neg_q <= s1_neg_q;
      s2_m_q   <= s2_m_d;
    end
    if (en[2]) begin
      s3_neg_q   <= s2_neg_q;
      s3_m_q     <= s2_m_q;
      s3_lin_q   <= s3_lin_d;
      s3_clipp_q <= s3_clipp_d;
      s3_le_q    <= s3_le_d;
      s3_mr_q    <= s3_mr_d;
    end
    if (en[3]) begin
      s4_neg_q    <= s3_neg_q;
      s4_region_q <= s4_region_d;
      s4_vlin_q   <= s4_vlin_d;
      s4_sq_q     <= s4_sq_d;
      s4_mr_q     <= s3_mr_q;
    end
    if (en[4]) begin
      s5_neg_q    <= s4_neg_q;
      s5_region_q <= s4_region_q;
      s5_vlin_q   <= s4_vlin_q;
      s5_pa_q     <= s5_pa_d;
      s5_pb_q     <= s5_pb_d;
    end
    if (en[5]) begin
      s6_region_q <= s5_region_q;
      s6_v_q      <= s6_v_d;
    end
    if (en[6]) begin
      s7_region_q <= s6_region_q;
      s7_z_q      <= s7_z_d;
    end
    if (en[7]) begin
      s8_region_q <= s7_region_q;
      s8_out_q    <= s8_out_d;
      s8_sat_q    <= s8_sat_d;
    end
  end

  assign out_valid_o  = vld_q[NST-1];
  assign sample_out_o = $signed(s8_out_q);
  assign region_o     = s8_region_q;
  assign saturated_o  = s8_sat_q;

endmodule

// File: tb/sv/shaper_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Soft clip waveshaper checker
// Watches the register, sample and result channels of the waveshaper. It
// keeps its own copy of the registers, computes the shaped sample, region and
// saturation flag for every accepted input beat, and compares each result beat
// field by field with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module shaper_checker (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_valid_i,
  input  logic                                    cfg_ready_i,
  input  logic [scw_pkg::CFG_IDX_W-1:0]           cfg_index_i,
  input  logic [scw_pkg::CFG_W-1:0]               cfg_data_i,
  input  logic                                    in_valid_i,
  input  logic                                    in_ready_i,
  input  logic signed [scw_pkg::SAMPLE_WIDTH-1:0] sample_in_i,
  input  logic                                    out_valid_i,
  input  logic                                    out_ready_i,
  input  logic signed [scw_pkg::SAMPLE_WIDTH-1:0] sample_out_i,
  input  logic [1:0]                              region_i,
  input  logic                                    saturated_i,
  output int                                      pending_o,
  output int                                      fail_cnt_o
);
  import scw_pkg::*;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] smp;
    region_e                        zone;
    logic                           sat;
  } shaped_t;

  shaped_t shaped_q[$];
  int      fails = 0;
  int      beat_no = 0;

  longint unsigned in_gain, out_gain, knee, slope, clip;
  longint          coef_a, coef_b, coef_c;

  assign fail_cnt_o = fails;

  function automatic longint unsigned shr_round(input longint unsigned v, input int sh);
    if (sh <= 0) return v;
    return (v + (64'd1 << (sh - 1))) >> sh;
  endfunction

  function automatic shaped_t shape_sample(input logic signed [SAMPLE_WIDTH-1:0] s);
    longint unsigned mag, x, m, t, mr, sq, zmag, r, lim;
    longint          v, z;
    logic            neg, zneg;
    int              fb;
    shaped_t         e;
    fb  = FRAC + 12;
    neg = s[SAMPLE_WIDTH-1];
    mag = {{(64-SAMPLE_WIDTH){1'b0}}, s};
    if (neg) mag = (64'd1 << SAMPLE_WIDTH) - mag;
    x = mag * in_gain;
    if (fb >= 32) m = shr_round(x, fb - 32);
    else m = x << (32 - fb);
    t = knee << 9;
    if (m <= t) begin
      e.zone = REG_LINEAR;
      v = longint'(shr_round(slope * m, 12));
    end else if ((m << 12) >= slope * t) begin
      e.zone = REG_CLIP;
      v = longint'(clip << 20);
    end else begin
      mr = shr_round(m, 12);
      sq = shr_round(mr * mr, 20);
      e.zone = REG_KNEE;
      v = coef_a * longint'(sq) + coef_b * longint'(mr) + coef_c * (longint'(1) << 20);
    end
    if (neg) v = -v;
    z    = v * longint'(out_gain);
    zneg = (z < 0);
    zmag = zneg ? -z : z;
    r    = shr_round(zmag, 44 - FRAC);
    lim  = (64'd1 << FRAC) - (zneg ? 64'd0 : 64'd1);
    e.sat = (r > lim);
    if (e.sat) r = lim;
    if (zneg) r = -r;
    e.smp = r[SAMPLE_WIDTH-1:0];
    return e;
  endfunction

  task automatic report_error(input string msg);
    $display("ERROR: %s", msg);
    fails++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    shaped_t want;
    if (!rst_ni) begin
      shaped_q.delete();
      in_gain   = IG_RST;
      out_gain  = OG_RST;
      knee      = KT_RST;
      slope     = LS_RST;
      clip      = CL_RST;
      coef_a    = QA_RST;
      coef_b    = QB_RST;
      coef_c    = QC_RST;
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (shaped_q.size() == 0) begin
          report_error($sformatf("result beat %0d arrived with no sample pending", beat_no));
        end else begin
          want = shaped_q.pop_front();
          if (sample_out_i !== want.smp)
            report_error($sformatf("beat %0d sample_out %0d, predicted %0d",
                                   beat_no, sample_out_i, want.smp));
          if (region_i !== want.zone)
            report_error($sformatf("beat %0d region %0d, predicted %0d",
                                   beat_no, region_i, want.zone));
          if (saturated_i !== want.sat)
            report_error($sformatf("beat %0d saturated %0b, predicted %0b",
                                   beat_no, saturated_i, want.sat));
        end
        beat_no++;
      end
      if (in_valid_i && in_ready_i) shaped_q.push_back(shape_sample(sample_in_i));
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_INPUT_GAIN:  in_gain  = cfg_data_i[GAIN_W-1:0];
          CFG_OUTPUT_GAIN: out_gain = cfg_data_i[GAIN_W-1:0];
          CFG_KNEE_THRESH: knee     = cfg_data_i[THR_W-1:0];
          CFG_LIN_SLOPE:   slope    = cfg_data_i[GAIN_W-1:0];
          CFG_CLIP_LEVEL:  clip     = cfg_data_i[GAIN_W-1:0];
          CFG_QUAD_A:      coef_a   = longint'($signed(cfg_data_i[GAIN_W-1:0]));
          CFG_QUAD_B:      coef_b   = longint'($signed(cfg_data_i[GAIN_W-1:0]));
          CFG_QUAD_C:      coef_c   = longint'($signed(cfg_data_i[GAIN_W-1:0]));
          default: ;
        endcase
      end
      pending_o <= shaped_q.size();
    end
  end

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Soft clip waveshaper testbench
// Drives register settings and samples into the waveshaper with random gaps
// and output stalls. A directed part covers the region boundaries, zero,
// full scale, negative knee values, a slope below one and extreme registers;
// random phases with new register settings follow. The checker beside the
// block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb;
  import scw_pkg::*;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]           cfg_index = '0;
  logic [CFG_W-1:0]               cfg_data = '0;
  logic                           in_valid = 1'b0;
  logic signed [SAMPLE_WIDTH-1:0] sample_in = '0;
  logic                           out_ready = 1'b0;
  logic                           cfg_ready, in_ready, out_valid, saturated;
  logic signed [SAMPLE_WIDTH-1:0] sample_out;
  logic [1:0]                     region;
  int                             pending, fail_cnt;

  logic   calm = 1'b0;
  int     stall_left = 0;
  longint cur_ig = IG_RST;
  longint cur_kt = KT_RST;
  longint cur_ls = LS_RST;

  always #6 clk = ~clk;

  soft_clip_waveshaper u_top (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .sample_in_i  (sample_in),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .sample_out_o (sample_out),
    .region_o     (region),
    .saturated_o  (saturated)
  );

  shaper_checker u_chk (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .sample_in_i  (sample_in),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .sample_out_i (sample_out),
    .region_i     (region),
    .saturated_i  (saturated),
    .pending_o    (pending),
    .fail_cnt_o   (fail_cnt)
  );

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left <= pick_gap();
    end
  end

  function automatic logic signed [SAMPLE_WIDTH-1:0] rand_sample();
    longint mag, hi;
    int     pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      case ($urandom_range(0, 3))
        0:       return SAT_POS;
        1:       return {1'b1, {FRAC{1'b0}}};
        2:       return '0;
        default: return '1;
      endcase
    end
    if (pick < 5) return SAMPLE_WIDTH'($urandom);
    if (pick < 8) begin
      mag = longint'($urandom_range(0, 1 << 20));
    end else begin
      // Spread around the knee of the current setting, up to a bit past clip start.
      hi = (cur_ig == 0) ? (64'd1 << FRAC) : ((cur_ls + 4096) * cur_kt) / cur_ig;
      if (hi > (64'd1 << FRAC)) hi = 64'd1 << FRAC;
      mag = longint'($urandom_range(0, int'(hi)));
    end
    return $urandom_range(0, 1) ? SAMPLE_WIDTH'(-mag) : SAMPLE_WIDTH'(mag);
  endfunction

  task automatic push_sample(input logic signed [SAMPLE_WIDTH-1:0] s);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    sample_in <= s;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic reconfigure(input longint ig, og, kt, ls, cl, qa, qb, qc);
    logic [CFG_W-1:0] vals [8];
    logic [CFG_W-1:0] mask;
    logic [CFG_W-1:0] d;
    in_valid <= 1'b0;
    drain();
    vals[CFG_INPUT_GAIN]  = CFG_W'(ig);
    vals[CFG_OUTPUT_GAIN] = CFG_W'(og);
    vals[CFG_KNEE_THRESH] = CFG_W'(kt);
    vals[CFG_LIN_SLOPE]   = CFG_W'(ls);
    vals[CFG_CLIP_LEVEL]  = CFG_W'(cl);
    vals[CFG_QUAD_A]      = CFG_W'(qa);
    vals[CFG_QUAD_B]      = CFG_W'(qb);
    vals[CFG_QUAD_C]      = CFG_W'(qc);
    for (int i = 0; i < 8; i++) begin
      if (cfg_idx_e'(i) == CFG_KNEE_THRESH) mask = {{(CFG_W-THR_W){1'b0}}, {THR_W{1'b1}}};
      else mask = {{(CFG_W-GAIN_W){1'b0}}, {GAIN_W{1'b1}}};
      // Upper bits carry junk; the block must ignore them.
      d = $urandom;
      cfg_valid <= 1'b1;
      cfg_index <= cfg_idx_e'(i);
      cfg_data  <= (d & ~mask) | (vals[i] & mask);
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    cur_ig = ig & 16'hFFFF;
    cur_kt = kt & 23'h7FFFFF;
    cur_ls = ls & 16'hFFFF;
  endtask

  initial begin
    int dir_a [14] = '{0, 1, -1, 8388607, -8388608, 1258291, -1258291, 1258292, -1258292,
                       5033163, -5033163, 5033164, -5033164, 3000000};
    int dir_b [5]  = '{3000000, -3000000, 8388607, -8388608, 0};
    int dir_c [2]  = '{1, -8388608};
    int dir_d [2]  = '{8388607, -4000};
    int dir_e [2]  = '{1258292, -4000000};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_a[i]) push_sample(SAMPLE_WIDTH'(dir_a[i]));
    reconfigure(4096, 65535, 1258291, 16384, 65535, -32768, -32768, -32768);
    foreach (dir_b[i]) push_sample(SAMPLE_WIDTH'(dir_b[i]));
    reconfigure(0, 0, 0, 0, 0, 0, 0, 0);
    foreach (dir_c[i]) push_sample(SAMPLE_WIDTH'(dir_c[i]));
    reconfigure(65535, 65535, 8388607, 65535, 65535, 32767, 32767, 32767);
    foreach (dir_d[i]) push_sample(SAMPLE_WIDTH'(dir_d[i]));
    reconfigure(4096, 2048, 1258291, 2048, 6963, -14542, 20747, -327);
    foreach (dir_e[i]) push_sample(SAMPLE_WIDTH'(dir_e[i]));

    for (int p = 0; p < 10; p++) begin
      calm <= ($urandom_range(0, 3) == 0);
      if (p == 0)
        reconfigure(IG_RST, OG_RST, KT_RST, LS_RST, CL_RST, QA_RST, QB_RST, QC_RST);
      else if (p % 4 == 3)
        reconfigure($urandom_range(0, 65535), $urandom_range(0, 65535),
                    $urandom_range(0, 8388607), $urandom_range(0, 65535),
                    $urandom_range(0, 65535), $urandom_range(0, 65535),
                    $urandom_range(0, 65535), $urandom_range(0, 65535));
      else
        reconfigure($urandom_range(512, 20000), $urandom_range(256, 12000),
                    $urandom_range(0, 4000000), $urandom_range(1024, 40000),
                    $urandom_range(0, 16384), $urandom_range(0, 65535),
                    $urandom_range(0, 65535), $urandom_range(0, 65535));
      repeat (70) push_sample(rand_sample());
    end

    in_valid <= 1'b0;
    drain();
    repeat (NST + 4) @(posedge clk);
    if (fail_cnt == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
